// ----- hw/rtl/iesp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iesp_pkg: shared types, constants and Q24.40 arithmetic helpers
// Coefficient store layout, command codes and saturating operators.
// ----------------------------------------------------------------------------
package iesp_pkg;

	localparam int COEF_DEPTH_DEF = 128;
	localparam int NSTATE = 9;
	localparam int NRESULT = 14;

	localparam int PHI_BASE = 0;
	localparam int CDT_BASE = 81;
	localparam int DRIVE_BASE = 90;
	localparam int OUT_BASE = 99;

	typedef logic signed [63:0] q_t;

	typedef enum logic [1:0] {
		CMD_LOAD_COEF = 2'd0,
		CMD_LOAD_ERR  = 2'd1,
		CMD_STEP      = 2'd2,
		CMD_NOP       = 2'd3
	} cmd_t;

	localparam q_t Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam q_t Q_MIN = 64'sh8000_0000_0000_0000;

	function automatic q_t sat_add(q_t a, q_t b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
		return s[63:0];
	endfunction

	function automatic q_t sat_sub(q_t a, q_t b);
		logic signed [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
		return s[63:0];
	endfunction

	// round half up on a full 128-bit product, then saturate
	function automatic q_t round_sat(logic signed [127:0] p);
		logic signed [127:0] r;
		logic signed [87:0] sh;
		r = p + (128'sd1 <<< 39);
		sh = r[127:40];
		if (sh[87:63] == '0 || sh[87:63] == '1) return sh[63:0];
		return sh[87] ? Q_MIN : Q_MAX;
	endfunction

endpackage

// ----- hw/rtl/iesp_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iesp_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module iesp_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- hw/rtl/iesp_mac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iesp_mac: pipelined Q24.40 multiplier
// Four 32x32 partial products in stage 1, sum in stage 2, round/saturate s3.
// ----------------------------------------------------------------------------
module iesp_mac (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	input  iesp_pkg::q_t    a,
	input  iesp_pkg::q_t    b,
	output logic            out_vld,
	output iesp_pkg::q_t    prod
);
	import iesp_pkg::*;

	logic [63:0] ma, mb;
	logic [63:0] ll_s1, lh_s1, hl_s1, hh_s1;
	logic        neg_s1, neg_s2;
	logic [127:0] mag_s2;
	logic        vld_s1, vld_s2, vld_s3;
	q_t          prod_s3;

	assign ma = a[63] ? 64'(-a) : a;
	assign mb = b[63] ? 64'(-b) : b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		ll_s1  <= ma[31:0] * mb[31:0];
		lh_s1  <= ma[31:0] * mb[63:32];
		hl_s1  <= ma[63:32] * mb[31:0];
		hh_s1  <= ma[63:32] * mb[63:32];
		neg_s1 <= a[63] ^ b[63];
		mag_s2 <= {64'd0, ll_s1} + ({64'd0, lh_s1} << 32) + ({64'd0, hl_s1} << 32)
			+ ({hh_s1, 64'd0});
		neg_s2 <= neg_s1;
		prod_s3 <= round_sat(neg_s2 ? -$signed(mag_s2) : $signed(mag_s2));
	end

	assign out_vld = vld_s3;
	assign prod = prod_s3;
endmodule

// ----- hw/rtl/iesp_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iesp_cell: one element of the error vector ring
// Holds one state word; rotates it to its neighbor, or loads or updates it.
// ----------------------------------------------------------------------------
module iesp_cell (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         shift,
	input  logic         load,
	input  iesp_pkg::q_t load_val,
	input  iesp_pkg::q_t from_prev,
	output iesp_pkg::q_t value
);
	import iesp_pkg::*;

	q_t val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else if (load) begin
			val_q <= load_val;
		end else if (shift) begin
			val_q <= from_prev;
		end
	end

	assign value = val_q;
endmodule

// ----- hw/rtl/ins_error_state_propagator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ins_error_state_propagator: nine-state INS error vector propagation
// X := Phi(acc) X + d on one pipelined MAC, state held in a ring of cells.
// ----------------------------------------------------------------------------
// channel | signals                                     | dir
// in      | valid ready cmd index load_value accel_xyz  | in
// out     | out_valid out_ready element result_value last| out
//
// Load items are accepted while idle. Every product (9 for p, 81 for the
// matrix, 8 for the derived outputs) goes through a coefficient read, an
// issue and 3 multiplier stages. Each matrix row then adds the drive term
// and advances the row. After a step the 14 results are emitted, then the
// input is ready again.
// Results stall freely on out_ready. Reset clears the vector and control.
// ----------------------------------------------------------------------------
module ins_error_state_propagator #(
	parameter int COEF_DEPTH = iesp_pkg::COEF_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid,
	output logic               ready,
	input  logic [1:0]         cmd,
	input  logic [6:0]         index,
	input  iesp_pkg::q_t       load_value,
	input  iesp_pkg::q_t       accel_x,
	input  iesp_pkg::q_t       accel_y,
	input  iesp_pkg::q_t       accel_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [3:0]         element,
	output iesp_pkg::q_t       result_value,
	output logic               last
);
	import iesp_pkg::*;

	localparam int AW = $clog2(COEF_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE, S_P_RD, S_P_MUL, S_X_RD, S_X_MUL, S_X_DRV, S_X_ROT,
		S_O_RD, S_O_MUL, S_EMIT
	} state_t;

	state_t state_q;
	q_t acc_q [3];
	q_t p_q [3];
	q_t res_q [NRESULT];
	logic [3:0] j_q, k_q;
	logic [3:0] o_q;
	q_t sum_q;
	q_t t_q;
	logic [3:0] emit_q;

	// coefficient RAM
	logic ram_we;
	logic [AW-1:0] ram_raddr;
	q_t ram_rdata;
	logic [7:0] raddr_full;

	assign ram_we = valid && ready && cmd == CMD_LOAD_COEF
		&& {2'b0, index} < 9'(COEF_DEPTH);

	iesp_ram #(.WIDTH(64), .DEPTH(COEF_DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .waddr(AW'(index)), .wdata(load_value),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	// ring of state cells; cell 0 is the head read by the MAC
	q_t cell_val [NSTATE];
	logic ring_shift;
	logic [NSTATE-1:0] cell_load;

	for (genvar g = 0; g < NSTATE; g++) begin : g_cell
		iesp_cell u_cell (
			.clk(clk), .arst_n(arst_n), .shift(ring_shift), .load(cell_load[g]),
			.load_val(ready ? load_value : res_q[g]),
			.from_prev(cell_val[(g + 1) % NSTATE]),
			.value(cell_val[g])
		);
	end

	// MAC
	logic mac_go, mac_vld;
	q_t mac_a, mac_b, mac_p;
	iesp_mac u_mac (
		.clk(clk), .arst_n(arst_n), .in_vld(mac_go), .a(mac_a), .b(mac_b),
		.out_vld(mac_vld), .prod(mac_p)
	);

	logic rd_wait_q;

	// Phi entry with the acceleration terms substituted
	function automatic logic is_dyn(logic [3:0] j, logic [3:0] k);
		return (j == 3 && (k == 1 || k == 2)) || (j == 4 && (k == 0 || k == 2))
			|| (j == 5 && (k == 0 || k == 1));
	endfunction

	q_t dyn_val;
	always_comb begin
		dyn_val = '0;
		case ({j_q, k_q})
			{4'd3, 4'd1}: dyn_val = sat_sub('0, p_q[2]);
			{4'd3, 4'd2}: dyn_val = p_q[1];
			{4'd4, 4'd0}: dyn_val = p_q[2];
			{4'd4, 4'd2}: dyn_val = sat_sub('0, p_q[0]);
			{4'd5, 4'd0}: dyn_val = sat_sub('0, p_q[1]);
			{4'd5, 4'd1}: dyn_val = p_q[0];
			default: dyn_val = '0;
		endcase
	end

	// output-term operand table: o_q steps through the eight derived products
	q_t o_a;
	always_comb begin
		o_a = '0;
		case (o_q)
			4'd0: o_a = res_q[7];
			4'd1: o_a = res_q[6];
			4'd2: o_a = res_q[1];
			4'd3: o_a = res_q[0];
			4'd4: o_a = res_q[1];
			4'd5: o_a = res_q[0];
			4'd6: o_a = sum_q;
			4'd7: o_a = sum_q;
			default: o_a = '0;
		endcase
	end

	always_comb begin
		raddr_full = '0;
		case (state_q)
			S_P_RD: raddr_full = 8'(CDT_BASE) + 8'(j_q) * 8'd3 + 8'(k_q);
			S_X_RD: raddr_full = 8'(PHI_BASE) + 8'(j_q) * 8'd9 + 8'(k_q);
			S_X_DRV: raddr_full = 8'(DRIVE_BASE) + 8'(j_q);
			default: begin
				case (o_q)
					4'd0: raddr_full = 8'(OUT_BASE);
					4'd1: raddr_full = 8'(OUT_BASE + 1);
					4'd2: raddr_full = 8'(OUT_BASE + 3);
					4'd3: raddr_full = 8'(OUT_BASE + 2);
					4'd4: raddr_full = 8'(OUT_BASE + 2);
					4'd5: raddr_full = 8'(OUT_BASE + 3);
					4'd6: raddr_full = 8'(OUT_BASE + 4);
					default: raddr_full = 8'(OUT_BASE + 5);
				endcase
			end
		endcase
	end
	assign ram_raddr = AW'(raddr_full);

	always_comb begin
		mac_a = ram_rdata;
		mac_b = cell_val[0];
		case (state_q)
			S_P_MUL: mac_b = acc_q[k_q[1:0]];
			S_X_MUL: if (is_dyn(j_q, k_q)) mac_a = dyn_val;
			S_O_MUL: mac_b = o_a;
			default: ;
		endcase
	end

	assign mac_go = rd_wait_q && (state_q == S_P_MUL || state_q == S_X_MUL
		|| state_q == S_O_MUL);

	assign ready = state_q == S_IDLE;

	// new vector goes back into the ring once the last row is done
	always_comb begin
		cell_load = '0;
		if (valid && ready && cmd == CMD_LOAD_ERR && index < 7'(NSTATE))
			cell_load[index[3:0]] = 1'b1;
		else if (state_q == S_X_ROT && j_q == 4'd8)
			cell_load = '1;
	end
	// nine shifts per row bring the head back to element 0
	assign ring_shift = state_q == S_X_MUL && mac_vld;

	logic mul_issued_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			j_q <= '0;
			k_q <= '0;
			o_q <= '0;
			emit_q <= '0;
			rd_wait_q <= 1'b0;
			mul_issued_q <= 1'b0;
		end else begin
			rd_wait_q <= state_q inside {S_P_RD, S_X_RD, S_O_RD};
			case (state_q)
				S_IDLE: begin
					if (valid && cmd == CMD_STEP) begin
						acc_q[0] <= accel_x;
						acc_q[1] <= accel_y;
						acc_q[2] <= accel_z;
						j_q <= '0;
						k_q <= '0;
						sum_q <= '0;
						state_q <= S_P_RD;
					end
				end
				S_P_RD: state_q <= S_P_MUL;
				S_P_MUL: if (mac_vld) begin
					if (k_q == 4'd2) begin
						p_q[j_q[1:0]] <= sat_add(sum_q, mac_p);
						sum_q <= '0;
						k_q <= '0;
						if (j_q == 4'd2) begin
							j_q <= '0;
							state_q <= S_X_RD;
						end else begin
							j_q <= j_q + 4'd1;
							state_q <= S_P_RD;
						end
					end else begin
						sum_q <= sat_add(sum_q, mac_p);
						k_q <= k_q + 4'd1;
						state_q <= S_P_RD;
					end
				end
				S_X_RD: state_q <= S_X_MUL;
				S_X_MUL: if (mac_vld) begin
					sum_q <= sat_add(sum_q, mac_p);
					if (k_q == 4'd8) begin
						k_q <= '0;
						state_q <= S_X_DRV;
						mul_issued_q <= 1'b0;
					end else begin
						k_q <= k_q + 4'd1;
						state_q <= S_X_RD;
					end
				end
				S_X_DRV: begin
					// address the drive term, then add the registered read data to the row sum
					if (mul_issued_q) begin
						res_q[j_q] <= sat_add(sum_q, ram_rdata);
						sum_q <= '0;
						mul_issued_q <= 1'b0;
						state_q <= S_X_ROT;
					end else begin
						mul_issued_q <= 1'b1;
					end
				end
				S_X_ROT: begin
					if (j_q == 4'd8) begin
						j_q <= '0;
						o_q <= '0;
						state_q <= S_O_RD;
					end else begin
						j_q <= j_q + 4'd1;
						state_q <= S_X_RD;
					end
				end
				S_O_RD: state_q <= S_O_MUL;
				S_O_MUL: if (mac_vld) begin
					state_q <= (o_q == 4'd7) ? S_EMIT : S_O_RD;
					o_q <= o_q + 4'd1;
					case (o_q)
						4'd0: res_q[9] <= mac_p;
						4'd1: res_q[10] <= mac_p;
						4'd2: t_q <= mac_p;
						4'd3: res_q[11] <= sat_sub(t_q, mac_p);
						4'd4: t_q <= mac_p;
						4'd5: sum_q <= sat_add(t_q, mac_p);
						4'd6: res_q[12] <= sat_sub('0, mac_p);
						default: begin
							res_q[13] <= sat_sub(res_q[2], mac_p);
							emit_q <= '0;
						end
					endcase
				end
				S_EMIT: if (out_ready) begin
					if (emit_q == 4'd13) begin
						state_q <= S_IDLE;
						emit_q <= '0;
					end else begin
						emit_q <= emit_q + 4'd1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		out_valid = state_q == S_EMIT;
		element = emit_q;
		last = emit_q == 4'd13;
		result_value = res_q[emit_q];
	end

	property p_ready_idle;
		@(posedge clk) disable iff (!arst_n) out_valid |-> !ready;
	endproperty
	assert property (p_ready_idle) else $error("ready during emit");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=> ready)
		else $error("no return to idle after last");

	assert property (@(posedge clk) disable iff (!arst_n)
		mac_vld |-> $past(mac_go, 3))
		else $error("stray multiplier result");
endmodule
